### rtl/hml_pkg.sv
// Shared types, widths and codes for the histogram matching lookup block.
package hml_pkg;

  localparam int unsigned LEVELS_DEF = 256;

  localparam int unsigned IDX_W    = 8;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned BIN_W    = 32;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned DNMIN_W  = 16;
  localparam int unsigned DN_W     = 17;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned THR_W    = FRAC_W + TOTAL_W;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 32;

  localparam logic [CNT_W-1:0] LEVEL_COUNT_RST = CNT_W'(256);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_BIN  = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DN_MIN      = 2'd0,
    CFG_LEVEL_COUNT = 2'd1,
    CFG_TOTAL_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                 is_bin;
    logic                 wr_en;
    logic [IDX_W-1:0]     idx;
    logic [FRAC_W-1:0]    frac;
    logic [BIN_W-1:0]     bin_count;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic                 upd;
    logic [DNMIN_W-1:0]   dn_min;
    logic [CNT_W-1:0]     level_count;
    logic [TOTAL_W-1:0]   total_count;
  } cfg_t;

endpackage

### rtl/hml_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hml_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hml_front.sv
// Input side: accepts beats, classifies them and holds them in a two-entry queue.
module hml_front import hml_pkg::*; #(
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // level_index, cdf_fraction, bin_count
  input  logic                  s_axis_tuser,  // func
  input  logic                  s_axis_tlast,
  output cmd_t                  cmd_o,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    cmd_in.is_bin    = (s_axis_tuser == FUNC_BIN);
    cmd_in.idx       = s_axis_tdata[IDX_W-1:0];
    cmd_in.frac      = s_axis_tdata[IDX_W +: FRAC_W];
    cmd_in.bin_count = s_axis_tdata[IDX_W+FRAC_W +: BIN_W];
    cmd_in.last      = s_axis_tlast;
    cmd_in.wr_en     = (s_axis_tuser == FUNC_LOAD) &&
                       ({{(32-IDX_W){1'b0}}, cmd_in.idx} < 32'(LEVELS));
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (count_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### rtl/hml_back.sv
// Execution side: table writes, level advance search and the output register.
module hml_back import hml_pkg::*; #(
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  cfg_t                   cfg_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // dn_value
  output logic                   m_axis_tuser,  // levels_exhausted
  output logic                   m_axis_tlast
);

  localparam int unsigned AW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned LV_W = $clog2(LEVELS + 1);
  localparam int unsigned NW   = (LV_W > CNT_W) ? LV_W : CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   lvl_q;
  logic [BIN_W-1:0]   run_q;
  logic [BIN_W:0]     sum_q;
  logic               last_q;
  logic [THR_W-1:0]   thr_q;
  logic               thr_vld_q;
  logic               out_vld_q;
  logic [DN_W-1:0]    out_dn_q;
  logic               out_exh_q;
  logic               out_last_q;

  logic [NW-1:0]      n_use;
  logic               exhausted;
  logic               reached;
  logic               out_free;
  logic               ram_we;
  logic [FRAC_W-1:0]  rd_data;
  logic [DN_W-1:0]    dn_value;

  always_comb begin
    n_use = (NW'(cfg_i.level_count) > NW'(LEVELS)) ? NW'(LEVELS) : NW'(cfg_i.level_count);
  end

  assign exhausted   = (NW'(lvl_q) >= n_use);
  assign reached     = ({sum_q, 16'b0} >= thr_q);
  assign out_free    = !out_vld_q || m_axis_tready;
  assign cmd_ready_o = (state_q == ST_IDLE) && (!cmd_i.is_bin || out_free);
  assign ram_we      = (state_q == ST_IDLE) && cmd_valid_i && !cmd_i.is_bin && cmd_i.wr_en;
  assign dn_value    = {{(DN_W-DNMIN_W){cfg_i.dn_min[DNMIN_W-1]}}, cfg_i.dn_min} +
                       {{(DN_W-CNT_W){1'b0}}, lvl_q};

  hml_ram #(
    .WIDTH(FRAC_W),
    .DEPTH(LEVELS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(cmd_i.idx)),
    .wdata_i(cmd_i.frac),
    .raddr_i(AW'(lvl_q)),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lvl_q      <= '0;
      run_q      <= '0;
      sum_q      <= '0;
      last_q     <= 1'b0;
      thr_q      <= '0;
      thr_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      out_dn_q   <= '0;
      out_exh_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            if (cmd_i.is_bin) begin
              sum_q   <= {1'b0, run_q} + {1'b0, cmd_i.bin_count};
              last_q  <= cmd_i.last;
              state_q <= ST_CHECK;
            end else if (cmd_i.wr_en) begin
              thr_vld_q <= 1'b0;
            end
          end
        end
        ST_CHECK: begin
          if (exhausted || (thr_vld_q && !reached)) begin
            out_vld_q  <= 1'b1;
            out_dn_q   <= dn_value;
            out_exh_q  <= exhausted;
            out_last_q <= last_q;
            if (last_q) begin
              lvl_q     <= '0;
              run_q     <= '0;
              thr_vld_q <= 1'b0;
            end else begin
              run_q <= sum_q[BIN_W] ? '1 : sum_q[BIN_W-1:0];
            end
            state_q <= ST_IDLE;
          end else if (thr_vld_q) begin
            lvl_q     <= lvl_q + CNT_W'(1);
            thr_vld_q <= 1'b0;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          thr_q     <= rd_data * cfg_i.total_count;
          thr_vld_q <= 1'b1;
          state_q   <= ST_CHECK;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_i.upd) begin
        thr_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-DN_W){1'b0}}, out_dn_q};
  assign m_axis_tuser  = out_exh_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### rtl/histogram_match_lut.sv
// Histogram specification lookup: maps histogram bins to output levels along a target curve.
// Load beats (tuser 0) write one target cumulative fraction into the level table.
// Bin beats (tuser 1) pass from the idle state to a check state; each time the running count
// passes a target the bin advances the level and goes again through the table read and the
// fraction-times-total multiply of the level search loop, and the first bin after a reset, a
// final bin, a table load or a register write also waits for the first table fetch.
// A two-entry queue in front lets input beats arrive while a result waits on the output side.
// There is no clearing pass; table entries must be loaded before a histogram reads them.
module histogram_match_lut import hml_pkg::*; #(
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // level_index, cdf_fraction, bin_count
  input  logic                   s_axis_tuser,   // func
  input  logic                   s_axis_tlast,   // last_bin
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // dn_value
  output logic                   m_axis_tuser,   // levels_exhausted
  output logic                   m_axis_tlast,   // last_out
  input  logic                   cfg_we_i,
  input  logic [CFG_AW-1:0]      cfg_idx_i,
  input  logic [CFG_DW-1:0]      cfg_data_i
);

  logic [DNMIN_W-1:0] dn_min_q;
  logic [CNT_W-1:0]   level_count_q;
  logic [TOTAL_W-1:0] total_count_q;
  cfg_t               cfg;
  cmd_t               cmd;
  logic               cmd_valid;
  logic               cmd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_min_q      <= '0;
      level_count_q <= LEVEL_COUNT_RST;
      total_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_DN_MIN:      dn_min_q      <= cfg_data_i[DNMIN_W-1:0];
        CFG_LEVEL_COUNT: level_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_TOTAL_COUNT: total_count_q <= cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.upd         = cfg_we_i;
    cfg.dn_min      = dn_min_q;
    cfg.level_count = level_count_q;
    cfg.total_count = total_count_q;
  end

  hml_front #(
    .LEVELS(LEVELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready)
  );

  hml_back #(
    .LEVELS(LEVELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cfg_i        (cfg),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

### rtl/hml_checker.sv
// Port-level checker for the histogram matching lookup block, bound to the top level.
module hml_checker import hml_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast,
  input logic                   cfg_we_i,
  input logic [CFG_AW-1:0]      cfg_idx_i,
  input logic [CFG_DW-1:0]      cfg_data_i
);

  logic [3:0]         pending_q;
  logic [DNMIN_W-1:0] dn_min_q;
  logic [CNT_W-1:0]   level_count_q;
  logic               bin_in;
  logic               res_out;
  logic [DN_W-1:0]    level_seen;

  assign bin_in     = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_BIN);
  assign res_out    = m_axis_tvalid && m_axis_tready;
  assign level_seen = m_axis_tdata[DN_W-1:0] -
                      {{(DN_W-DNMIN_W){dn_min_q[DNMIN_W-1]}}, dn_min_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      dn_min_q      <= '0;
      level_count_q <= LEVEL_COUNT_RST;
    end else begin
      pending_q <= pending_q + 4'(bin_in) - 4'(res_out);
      if (cfg_we_i && (cfg_idx_i == CFG_DN_MIN)) begin
        dn_min_q <= cfg_data_i[DNMIN_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_LEVEL_COUNT)) begin
        level_count_q <= cfg_data_i[CNT_W-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 4'd0)
    else $error("result beat without a matching bin beat");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> level_seen < {{(DN_W-CNT_W){1'b0}}, level_count_q})
    else $error("level at or beyond the level count without the exhausted flag");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result beat valid straight after reset");

endmodule

bind histogram_match_lut hml_checker u_hml_checker (.*);

### bench/tb_top.sv
// Self-checking stream testbench for the histogram specification lookup block.
module tb_top;
  import hml_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 140;

  typedef struct packed {
    logic [DN_W-1:0] dn_value;
    logic            levels_exhausted;
    logic            last_out;
  } bin_result_t;

  typedef struct packed {
    logic               is_wr;
    cfg_reg_e           addr;
    logic [CFG_DW-1:0]  wdata;
    logic               func;
    logic [IDX_W-1:0]   idx;
    logic [FRAC_W-1:0]  frac;
    logic [BIN_W-1:0]   cnt;
    logic               last;
    logic               typed;
    bin_result_t        want;
  } step_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]      cfg_idx_i = '0;
  logic [CFG_DW-1:0]      cfg_data_i = '0;

  logic [FRAC_W-1:0]  cdf_table [LEVELS_DEF];
  logic [CNT_W-1:0]   cur_level = '0;
  logic [BIN_W-1:0]   run_count = '0;
  logic [DNMIN_W-1:0] dn_min_q = '0;
  logic [CNT_W-1:0]   lvl_cnt_q = LEVEL_COUNT_RST;
  logic [TOTAL_W-1:0] total_q = '0;

  bin_result_t expected_map_q[$];
  step_t       directed[$];
  int          n_errors = 0;
  int          quiet_cycles = 0;
  int          src_idle_pct = 21;
  int          snk_stall_pct = 21;
  bit          hold_off_req = 1'b0;

  histogram_match_lut #(.LEVELS(LEVELS_DEF)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic bin_result_t map_bin(input logic [BIN_W-1:0] cnt, input logic last);
    logic [BIN_W:0]     sum;
    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   lvl;
    logic [THR_W-1:0]   scaled;
    logic [THR_W-1:0]   thr;
    bin_result_t        r;
    sum = {1'b0, run_count} + {1'b0, cnt};
    n = (lvl_cnt_q > CNT_W'(LEVELS_DEF)) ? CNT_W'(LEVELS_DEF) : lvl_cnt_q;
    lvl = cur_level;
    scaled = {sum, 16'h0000};
    while (lvl < n) begin
      thr = THR_W'(cdf_table[lvl[IDX_W-1:0]]) * THR_W'(total_q);
      if (scaled < thr) break;
      lvl = lvl + 1'b1;
    end
    cur_level = lvl;
    run_count = sum[BIN_W] ? '1 : sum[BIN_W-1:0];
    r.dn_value = {dn_min_q[DNMIN_W-1], dn_min_q} + DN_W'(lvl);
    r.levels_exhausted = (lvl >= n);
    r.last_out = last;
    if (last) begin
      cur_level = '0;
      run_count = '0;
    end
    return r;
  endfunction

  function automatic step_t load_row(input logic [IDX_W-1:0] idx,
                                     input logic [FRAC_W-1:0] frac, input logic last);
    step_t s;
    s = '0;
    s.func = FUNC_LOAD;
    s.idx = idx;
    s.frac = frac;
    s.cnt = BIN_W'(32'hA5A5_5A5A);
    s.last = last;
    return s;
  endfunction

  function automatic step_t bin_row(input logic [BIN_W-1:0] cnt, input logic last);
    step_t s;
    s = '0;
    s.func = FUNC_BIN;
    s.idx = IDX_W'(8'hFF);
    s.frac = '1;
    s.cnt = cnt;
    s.last = last;
    return s;
  endfunction

  function automatic step_t checked_bin(input logic [BIN_W-1:0] cnt, input logic last,
                                        input logic [DN_W-1:0] dn, input logic exh);
    step_t s;
    s = bin_row(cnt, last);
    s.typed = 1'b1;
    s.want = '{dn_value: dn, levels_exhausted: exh, last_out: last};
    return s;
  endfunction

  function automatic step_t wr_row(input cfg_reg_e addr, input logic [CFG_DW-1:0] value);
    step_t s;
    s = '0;
    s.is_wr = 1'b1;
    s.addr = addr;
    s.wdata = value;
    return s;
  endfunction

  task automatic send_beat(input logic func, input logic [IDX_W-1:0] idx,
                           input logic [FRAC_W-1:0] frac, input logic [BIN_W-1:0] cnt,
                           input logic last, input logic typed, input bin_result_t want);
    bin_result_t got;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, cnt, frac, idx};
    s_axis_tuser <= func;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FUNC_LOAD) begin
      cdf_table[idx] = frac;
    end else begin
      got = map_bin(cnt, last);
      expected_map_q.push_back(typed ? want : got);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_map_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e addr, input logic [CFG_DW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= addr;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      CFG_DN_MIN:      dn_min_q = value[DNMIN_W-1:0];
      CFG_LEVEL_COUNT: lvl_cnt_q = value[CNT_W-1:0];
      CFG_TOTAL_COUNT: total_q = value[TOTAL_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    bin_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_map_q.size() == 0) begin
        $error("unexpected result beat: dn_value %0d", $signed(m_axis_tdata[DN_W-1:0]));
        n_errors++;
      end else begin
        want = expected_map_q.pop_front();
        if (m_axis_tdata[DN_W-1:0] !== want.dn_value) begin
          $error("dn_value: expected %0d, got %0d", $signed(want.dn_value),
                 $signed(m_axis_tdata[DN_W-1:0]));
          n_errors++;
        end
        if (m_axis_tuser !== want.levels_exhausted) begin
          $error("levels_exhausted: expected %0b, got %0b", want.levels_exhausted,
                 m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tlast !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("histogram_match_lut test failed");
      $finish;
    end
  end

  initial begin
    int                 p;
    int                 i;
    int                 b;
    int                 nb;
    int                 sent;
    int                 v;
    int                 n_use;
    logic [DNMIN_W-1:0] dn;
    logic [CNT_W-1:0]   lc;
    logic [TOTAL_W-1:0] tot;
    logic [BIN_W-1:0]   c;
    logic [63:0]        avg;
    logic [63:0]        c64;

    foreach (cdf_table[k]) cdf_table[k] = '0;

    // Registers still hold their reset values apart from the level count: a zero total
    // means every target is reached at once.
    directed.push_back(load_row(8'd0, 17'd0, 1'b0));
    directed.push_back(load_row(8'd1, 17'd16384, 1'b0));
    directed.push_back(load_row(8'd2, 17'd32768, 1'b0));
    directed.push_back(load_row(8'd3, 17'd65536, 1'b0));
    directed.push_back(wr_row(CFG_LEVEL_COUNT, 32'd4));
    directed.push_back(checked_bin(32'd5, 1'b1, DN_W'(4), 1'b1));
    directed.push_back(wr_row(CFG_DN_MIN, 32'h0000_8000));
    directed.push_back(wr_row(CFG_TOTAL_COUNT, 32'd1000));
    directed.push_back(bin_row(32'd0, 1'b0));
    directed.push_back(bin_row(32'd250, 1'b0));
    directed.push_back(bin_row(32'd750, 1'b0));
    directed.push_back(bin_row(32'hFFFF_FFFF, 1'b0));
    directed.push_back(checked_bin(32'hFFFF_FFFF, 1'b1, DN_W'(-32764), 1'b1));
    directed.push_back(load_row(8'd255, 17'd131071, 1'b1));
    directed.push_back(wr_row(CFG_DN_MIN, 32'h0000_7FFF));
    directed.push_back(bin_row(32'd0, 1'b0));
    // Level count dropped below the level already reached, then raised past the table size.
    directed.push_back(wr_row(CFG_LEVEL_COUNT, 32'd0));
    directed.push_back(bin_row(32'd100, 1'b0));
    directed.push_back(wr_row(CFG_LEVEL_COUNT, 32'd511));
    directed.push_back(bin_row(32'd0, 1'b1));
    directed.push_back(wr_row(CFG_LEVEL_COUNT, 32'd0));
    directed.push_back(checked_bin(32'd7, 1'b1, DN_W'(32767), 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      if (directed[k].is_wr) begin
        wait_idle();
        write_reg(directed[k].addr, directed[k].wdata);
      end else begin
        send_beat(directed[k].func, directed[k].idx, directed[k].frac, directed[k].cnt,
                  directed[k].last, directed[k].typed, directed[k].want);
      end
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case (p % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 74; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 74; end
        default: begin src_idle_pct = 21; snk_stall_pct = 21; end
      endcase
      case (p)
        0: begin dn = 16'h0000; lc = 9'd256; tot = $urandom_range(100000, 1000); end
        1: begin dn = 16'h8000; lc = 9'd1;   tot = 32'hFFFF_FFFF; end
        2: begin dn = 16'h7FFF; lc = 9'd511; tot = $urandom; end
        3: begin dn = DNMIN_W'($urandom); lc = 9'd0; tot = 32'd0; end
        6: begin
          dn = DNMIN_W'($urandom);
          lc = CNT_W'($urandom_range(255, 64));
          tot = $urandom_range(50000, 1);
        end
        default: begin
          dn = DNMIN_W'($urandom);
          lc = CNT_W'($urandom_range(24, 2));
          tot = $urandom >> $urandom_range(31, 0);
        end
      endcase
      write_reg(CFG_DN_MIN, {16'b0, dn});
      write_reg(CFG_LEVEL_COUNT, {23'b0, lc});
      write_reg(CFG_TOTAL_COUNT, tot);

      // A rising target curve with jitter and the odd wild entry.
      n_use = (lc > 9'd256) ? 256 : int'(lc);
      for (i = 0; i < n_use; i++) begin
        v = ((i + 1) * 65536) / n_use - int'($urandom_range(255));
        if (v < 0) v = 0;
        if ($urandom_range(15) == 0) v = int'($urandom_range(131071));
        send_beat(FUNC_LOAD, IDX_W'(i), FRAC_W'(v), $urandom, 1'($urandom_range(1)),
                  1'b0, '0);
      end

      if (p == 4) hold_off_req = 1'b1;
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        nb = $urandom_range(24, 1);
        avg = 64'(tot) / 64'(nb);
        for (b = 0; b < nb; b++) begin
          if ($urandom_range(9) == 0) begin
            send_beat(FUNC_LOAD, IDX_W'($urandom), FRAC_W'($urandom), $urandom,
                      1'($urandom_range(1)), 1'b0, '0);
            sent++;
          end
          case ($urandom_range(9))
            0:       c = '0;
            1:       c = $urandom;
            2:       c = $urandom_range(15);
            default: begin
              c64 = avg * 64'($urandom_range(200)) / 64'd100;
              c = c64[BIN_W-1:0];
            end
          endcase
          send_beat(FUNC_BIN, IDX_W'($urandom), FRAC_W'($urandom), c, (b == nb - 1),
                    1'b0, '0);
          sent++;
        end
      end
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("histogram_match_lut test passed");
    end else begin
      $display("histogram_match_lut test failed");
    end
    $finish;
  end

endmodule
